/* rtl/cau_pkg.sv */
// ----------------------------------------------------------------------------
// cau_pkg: shared types and helpers for the complex arithmetic unit
// Word format, request/response beats, opcodes, status codes and the
// round/saturate functions used by the sequencer.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int WORD_W = 32;                     // word width
  localparam int FRAC_W = 16;                     // fraction bits
  localparam int EXP_W  = 8;                      // exponent field width
  localparam int PROD_W = 2 * WORD_W;             // exact product width
  localparam int ACC_W  = PROD_W + 2;             // sum of products, signed
  localparam int QUO_W  = PROD_W + FRAC_W + 1;    // scaled dividend / quotient
  localparam int DIV_CW = $clog2(QUO_W);          // divider step counter
  localparam int SQ_CW  = $clog2(WORD_W);         // square root step counter

  // opcodes
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_POW = 3'd4;
  localparam logic [2:0] OP_MAG = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef struct packed {
    logic [2:0]               op;
    logic signed [WORD_W-1:0] a_re;
    logic signed [WORD_W-1:0] a_im;
    logic signed [WORD_W-1:0] b_re;
    logic signed [WORD_W-1:0] b_im;
    logic signed [EXP_W-1:0]  exponent;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] res_re;
    logic signed [WORD_W-1:0] res_im;
    logic [1:0]               status;
  } rsp_t;

  typedef struct packed {
    logic [WORD_W-1:0] val;
    logic              ovf;
  } sat_t;

  // sign-extend a word into the accumulator width
  function automatic logic [ACC_W-1:0] sext_w(input logic [WORD_W-1:0] x);
    return {{(ACC_W-WORD_W){x[WORD_W-1]}}, x};
  endfunction

  // sign-extend a product into the accumulator width
  function automatic logic [ACC_W-1:0] sext_p(input logic [PROD_W-1:0] x);
    return {{(ACC_W-PROD_W){x[PROD_W-1]}}, x};
  endfunction

  // clamp a sign/magnitude value to the word range
  function automatic sat_t sat_mag(input logic neg, input logic [QUO_W-1:0] mag);
    sat_t r;
    logic [QUO_W-1:0] lim;
    logic [QUO_W-1:0] nm;
    lim = QUO_W'(1) << (WORD_W - 1);
    nm  = QUO_W'(0) - mag;
    if (neg) begin
      if (mag > lim) begin
        r.val = {1'b1, {(WORD_W-1){1'b0}}};
        r.ovf = 1'b1;
      end else begin
        r.val = nm[WORD_W-1:0];
        r.ovf = 1'b0;
      end
    end else if (mag >= lim) begin
      r.val = {1'b0, {(WORD_W-1){1'b1}}};
      r.ovf = 1'b1;
    end else begin
      r.val = mag[WORD_W-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  // two's complement accumulator to saturated word, no rounding
  function automatic sat_t sat_acc(input logic [ACC_W-1:0] v);
    logic neg;
    logic [ACC_W-1:0] m;
    neg = v[ACC_W-1];
    m   = neg ? (ACC_W'(0) - v) : v;
    return sat_mag(neg, QUO_W'(m));
  endfunction

  // drop the fraction bits, round half away from zero, then saturate
  function automatic sat_t round_acc(input logic [ACC_W-1:0] v);
    logic neg;
    logic [ACC_W-1:0] m;
    logic [ACC_W-1:0] r;
    neg = v[ACC_W-1];
    m   = neg ? (ACC_W'(0) - v) : v;
    r   = (m + (ACC_W'(1) << (FRAC_W - 1))) >> FRAC_W;
    return sat_mag(neg, QUO_W'(r));
  endfunction

endpackage

/* rtl/cau_mul.sv */
// ----------------------------------------------------------------------------
// cau_mul: shared signed word multiplier
// One full-precision signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module cau_mul (
  input  logic                                    clk,
  input  logic signed [cau_pkg::WORD_W-1:0]       a,
  input  logic signed [cau_pkg::WORD_W-1:0]       b,
  output logic        [cau_pkg::PROD_W-1:0]       p
);

  logic signed [cau_pkg::PROD_W-1:0] p_next;

  // exact signed product
  assign p_next = a * b;

  always_ff @(posedge clk) begin
    p <= p_next;
  end

endmodule

/* rtl/cau_div.sv */
// ----------------------------------------------------------------------------
// cau_div: restoring divider
// Unsigned quotient of a scaled dividend by a nonzero divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module cau_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [cau_pkg::QUO_W-1:0]   num,
  input  logic [cau_pkg::PROD_W-1:0]  den,
  output logic                        done,
  output logic [cau_pkg::QUO_W-1:0]   quo
);

  logic                        busy;
  logic [cau_pkg::DIV_CW-1:0]  cnt;
  logic [cau_pkg::PROD_W-1:0]  rem;
  logic [cau_pkg::PROD_W:0]    trial;
  logic [cau_pkg::PROD_W:0]    diff;
  logic                        ge;

  // shift in the next dividend bit and try the subtract
  assign trial = {rem, quo[cau_pkg::QUO_W-1]};
  assign diff  = trial - {1'b0, den};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= num;
      end else if (busy) begin
        rem <= ge ? diff[cau_pkg::PROD_W-1:0] : trial[cau_pkg::PROD_W-1:0];
        quo <= {quo[cau_pkg::QUO_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == cau_pkg::DIV_CW'(cau_pkg::QUO_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/cau_sqrt.sv */
// ----------------------------------------------------------------------------
// cau_sqrt: bitwise integer square root
// One root bit a cycle, then a final round-to-nearest step.
// ----------------------------------------------------------------------------
module cau_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [cau_pkg::PROD_W-1:0]  rad,
  output logic                        done,
  output logic [cau_pkg::PROD_W-1:0]  root
);

  logic                        busy;
  logic                        fin;
  logic [cau_pkg::SQ_CW-1:0]   cnt;
  logic [cau_pkg::PROD_W-1:0]  rest;
  logic [cau_pkg::PROD_W-1:0]  bt;
  logic [cau_pkg::PROD_W:0]    trial;
  logic                        take;

  // candidate for this bit
  assign trial = {1'b0, root} + {1'b0, bt};
  assign take  = {1'b0, rest} >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        fin  <= 1'b0;
        cnt  <= '0;
        rest <= rad;
        root <= '0;
        bt   <= cau_pkg::PROD_W'(1) << (cau_pkg::PROD_W - 2);
      end else if (fin) begin
        // round up when the remainder exceeds the root
        if (rest > root) root <= root + 1'b1;
        fin  <= 1'b0;
        done <= 1'b1;
      end else if (busy) begin
        if (take) begin
          rest <= rest - trial[cau_pkg::PROD_W-1:0];
          root <= (root >> 1) + bt;
        end else begin
          root <= root >> 1;
        end
        bt  <= bt >> 2;
        cnt <= cnt + 1'b1;
        if (cnt == cau_pkg::SQ_CW'(cau_pkg::WORD_W - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/complex_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// complex_arithmetic_unit: complex ALU on signed fixed-point words
// Sequencer around one shared multiplier, a divider and a square root unit.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) takes one beat: opcode, operands
//   A and B, exponent. rsp channel (rsp_valid/rsp_ready/rsp) returns one beat
//   per request: real and imaginary parts and a status code.
//   The unit works on one request at a time; req_ready is high only while the
//   sequencer is idle. Add, sub, power n <= 1, zero divisor and unused opcodes
//   are resolved at acceptance; multiply is one pass of four products through
//   the shared multiplier and power n >= 2 is n such passes; magnitude is two
//   products then the square root (one bit a cycle); divide is six products
//   then two divisions, real then imaginary (one quotient bit a cycle).
//   The result sits in an output register; if rsp_ready is low the sequencer
//   waits until it can load the register, and req_ready rises in the cycle
//   after the new result has been loaded.
//   Reset (rst, synchronous) returns to idle and drops rsp_valid.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  cau_pkg::req_t   req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output cau_pkg::rsp_t   rsp
);

  typedef enum logic [2:0] {
    S_IDLE, S_ISSUE, S_ACC, S_POST, S_DIV_RE, S_DIV_IM, S_SQRT, S_OUT
  } state_t;

  typedef enum logic [1:0] {T_RE, T_IM, T_DEN} tgt_t;

  state_t                       state;
  logic [2:0]                   opc;
  logic [cau_pkg::WORD_W-1:0]   xr, xi, yr, yi;
  logic [cau_pkg::ACC_W-1:0]    acc_re, acc_im, acc_den;
  logic [2:0]                   k;
  logic [cau_pkg::EXP_W-2:0]    cnt;
  logic                         ovf;
  logic [cau_pkg::WORD_W-1:0]   out_re, out_im;
  logic [1:0]                   out_st;
  logic                         div_start, sqrt_start;
  logic [cau_pkg::QUO_W-1:0]    div_num;

  logic [cau_pkg::WORD_W-1:0]   sel_a, sel_b;
  tgt_t                         tgt;
  logic                         sub;
  logic                         last;
  logic [cau_pkg::PROD_W-1:0]   prod;
  logic [cau_pkg::ACC_W-1:0]    prod_x;
  logic                         div_done, sqrt_done;
  logic [cau_pkg::QUO_W-1:0]    quo;
  logic [cau_pkg::PROD_W-1:0]   root;
  logic [cau_pkg::ACC_W-1:0]    sum_re, sum_im;
  logic [cau_pkg::QUO_W-1:0]    quo_rnd;
  logic [cau_pkg::ACC_W-1:0]    mag_re, mag_im;
  cau_pkg::sat_t                s_re, s_im, s_q, s_rt, s_one;
  logic                         req_fire, b_zero, e_le0, e_one;

  assign req_ready = (state == S_IDLE);
  assign req_fire  = req_valid && req_ready;

  // product schedule: operand pair, accumulator and sign for step k
  always_comb begin
    sel_a = xr;
    sel_b = yr;
    tgt   = T_RE;
    sub   = 1'b0;
    last  = 1'b0;
    case (opc)
      cau_pkg::OP_DIV: begin
        case (k)
          3'd0: begin sel_a = yr; sel_b = yr; tgt = T_DEN; end
          3'd1: begin sel_a = yi; sel_b = yi; tgt = T_DEN; end
          3'd2: begin sel_a = xr; sel_b = yr; tgt = T_RE; end
          3'd3: begin sel_a = xi; sel_b = yi; tgt = T_RE; end
          3'd4: begin sel_a = xi; sel_b = yr; tgt = T_IM; end
          default: begin sel_a = xr; sel_b = yi; tgt = T_IM; sub = 1'b1; last = 1'b1; end
        endcase
      end
      cau_pkg::OP_MAG: begin
        sel_a = (k == 3'd0) ? xr : xi;
        sel_b = sel_a;
        last  = (k != 3'd0);
      end
      default: begin
        // multiply and power: (x_re + i x_im) * (y_re + i y_im)
        case (k)
          3'd0: begin sel_a = xr; sel_b = yr; tgt = T_RE; end
          3'd1: begin sel_a = xi; sel_b = yi; tgt = T_RE; sub = 1'b1; end
          3'd2: begin sel_a = xr; sel_b = yi; tgt = T_IM; end
          default: begin sel_a = xi; sel_b = yr; tgt = T_IM; last = 1'b1; end
        endcase
      end
    endcase
  end

  cau_mul u_mul (
    .clk (clk),
    .a   (sel_a),
    .b   (sel_b),
    .p   (prod)
  );

  cau_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (acc_den[cau_pkg::PROD_W-1:0]),
    .done  (div_done),
    .quo   (quo)
  );

  cau_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .rad   (acc_re[cau_pkg::PROD_W-1:0]),
    .done  (sqrt_done),
    .root  (root)
  );

  // signed product, negated for subtracted terms
  assign prod_x = sub ? (cau_pkg::ACC_W'(0) - cau_pkg::sext_p(prod))
                      : cau_pkg::sext_p(prod);

  // add / subtract on the raw request
  assign sum_re = (req.op == cau_pkg::OP_SUB)
                ? cau_pkg::sext_w(req.a_re) - cau_pkg::sext_w(req.b_re)
                : cau_pkg::sext_w(req.a_re) + cau_pkg::sext_w(req.b_re);
  assign sum_im = (req.op == cau_pkg::OP_SUB)
                ? cau_pkg::sext_w(req.a_im) - cau_pkg::sext_w(req.b_im)
                : cau_pkg::sext_w(req.a_im) + cau_pkg::sext_w(req.b_im);

  // result shaping
  assign s_re   = (state == S_IDLE) ? cau_pkg::sat_acc(sum_re) : cau_pkg::round_acc(acc_re);
  assign s_im   = (state == S_IDLE) ? cau_pkg::sat_acc(sum_im) : cau_pkg::round_acc(acc_im);
  assign s_one  = cau_pkg::sat_mag(1'b0, cau_pkg::QUO_W'(1) << cau_pkg::FRAC_W);
  assign s_rt   = cau_pkg::sat_mag(1'b0, cau_pkg::QUO_W'(root));
  assign quo_rnd = (quo + 1'b1) >> 1;
  assign s_q    = cau_pkg::sat_mag((state == S_DIV_RE) ? acc_re[cau_pkg::ACC_W-1]
                                                     : acc_im[cau_pkg::ACC_W-1], quo_rnd);

  // dividend magnitudes, later scaled with one extra bit for rounding
  assign mag_re = acc_re[cau_pkg::ACC_W-1] ? (cau_pkg::ACC_W'(0) - acc_re) : acc_re;
  assign mag_im = acc_im[cau_pkg::ACC_W-1] ? (cau_pkg::ACC_W'(0) - acc_im) : acc_im;

  assign b_zero = (req.b_re == '0) && (req.b_im == '0);
  assign e_le0  = req.exponent[cau_pkg::EXP_W-1] || (req.exponent == '0);
  assign e_one  = (req.exponent == cau_pkg::EXP_W'(1));

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      div_start  <= 1'b0;
      sqrt_start <= 1'b0;
    end else begin
      div_start  <= 1'b0;
      sqrt_start <= 1'b0;
      // result beat taken; S_OUT reloads in the same cycle when it can
      if (rsp_valid && rsp_ready && (state != S_OUT)) rsp_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            opc     <= req.op;
            xr      <= req.a_re;
            xi      <= req.a_im;
            yr      <= req.b_re;
            yi      <= req.b_im;
            acc_re  <= '0;
            acc_im  <= '0;
            acc_den <= '0;
            k       <= '0;
            ovf     <= 1'b0;
            out_re  <= '0;
            out_im  <= '0;
            out_st  <= cau_pkg::ST_OK;
            state   <= S_OUT;
            case (req.op)
              cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
                out_re <= s_re.val;
                out_im <= s_im.val;
                out_st <= (s_re.ovf || s_im.ovf) ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
              end
              cau_pkg::OP_MUL, cau_pkg::OP_MAG: state <= S_ISSUE;
              cau_pkg::OP_DIV: begin
                if (b_zero) out_st <= cau_pkg::ST_DIVZ;
                else state <= S_ISSUE;
              end
              cau_pkg::OP_POW: begin
                if (e_le0) begin
                  out_re <= s_one.val;
                  out_st <= s_one.ovf ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
                end else if (e_one) begin
                  out_re <= req.a_re;
                  out_im <= req.a_im;
                end else begin
                  // z = 1 + 0i, then z = z * A per pass
                  xr    <= s_one.val;
                  xi    <= '0;
                  yr    <= req.a_re;
                  yi    <= req.a_im;
                  ovf   <= s_one.ovf;
                  cnt   <= req.exponent[cau_pkg::EXP_W-2:0];
                  state <= S_ISSUE;
                end
              end
              default: ;
            endcase
          end
        end
        S_ISSUE: state <= S_ACC;
        S_ACC: begin
          case (tgt)
            T_RE:    acc_re  <= acc_re + prod_x;
            T_IM:    acc_im  <= acc_im + prod_x;
            default: acc_den <= acc_den + prod_x;
          endcase
          if (last) state <= S_POST;
          else begin
            k     <= k + 1'b1;
            state <= S_ISSUE;
          end
        end
        S_POST: begin
          case (opc)
            cau_pkg::OP_DIV: begin
              div_num   <= cau_pkg::QUO_W'(mag_re) << (cau_pkg::FRAC_W + 1);
              div_start <= 1'b1;
              state     <= S_DIV_RE;
            end
            cau_pkg::OP_MAG: begin
              sqrt_start <= 1'b1;
              state      <= S_SQRT;
            end
            cau_pkg::OP_POW: begin
              xr      <= s_re.val;
              xi      <= s_im.val;
              ovf     <= ovf || s_re.ovf || s_im.ovf;
              acc_re  <= '0;
              acc_im  <= '0;
              k       <= '0;
              cnt     <= cnt - 1'b1;
              if (cnt == (cau_pkg::EXP_W-1)'(1)) begin
                out_re <= s_re.val;
                out_im <= s_im.val;
                out_st <= (ovf || s_re.ovf || s_im.ovf) ? cau_pkg::ST_OVF
                                                         : cau_pkg::ST_OK;
                state  <= S_OUT;
              end else begin
                state  <= S_ISSUE;
              end
            end
            default: begin
              out_re <= s_re.val;
              out_im <= s_im.val;
              out_st <= (s_re.ovf || s_im.ovf) ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
              state  <= S_OUT;
            end
          endcase
        end
        S_DIV_RE: begin
          if (div_done) begin
            out_re    <= s_q.val;
            ovf       <= s_q.ovf;
            div_num   <= cau_pkg::QUO_W'(mag_im) << (cau_pkg::FRAC_W + 1);
            div_start <= 1'b1;
            state     <= S_DIV_IM;
          end
        end
        S_DIV_IM: begin
          if (div_done) begin
            out_im <= s_q.val;
            out_st <= (ovf || s_q.ovf) ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
            state  <= S_OUT;
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            out_re <= s_rt.val;
            out_im <= '0;
            out_st <= s_rt.ovf ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
            state  <= S_OUT;
          end
        end
        S_OUT: begin
          // load the output register once it is free
          if (!rsp_valid || rsp_ready) begin
            rsp.res_re <= out_re;
            rsp.res_im <= out_im;
            rsp.status <= out_st;
            rsp_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/cau_checker.sv */
// ----------------------------------------------------------------------------
// cau_checker: port-level checks for the complex arithmetic unit
// Watches both channels and the result status; bound to the top level.
// ----------------------------------------------------------------------------
module cau_checker (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_ready,
  input cau_pkg::req_t   req,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input cau_pkg::rsp_t   rsp
);

  // a stalled result beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result beat changed while stalled");

  // a waiting request beat holds
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req))
    else $error("request beat changed while waiting");

  // one request at a time: busy right after an accepted beat
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while busy");

  // status code is always defined
  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status != 2'd3)
    else $error("undefined status code");

  // divide by zero returns zero
  a_divz: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == cau_pkg::ST_DIVZ) |-> (rsp.res_re == '0) && (rsp.res_im == '0))
    else $error("nonzero result on divide by zero");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking testbench for complex_arithmetic_unit
// Drives request beats over valid/ready, takes expected responses from the
// directed table or a bit-accurate fixed-point model of the complex ALU, and
// checks each response beat field by field in order. The table comes first,
// then random beats under three idling patterns and one long response stall.
// ----------------------------------------------------------------------------
module tb;
  import cau_pkg::*;

  localparam int N_RANDOM  = 1400;
  localparam int WDOG_MAX  = 5000;
  localparam int HOLD_LEN  = 400;
  localparam int DRAIN_CYC = 1200;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    req_t r;
    bit   typed;
    rsp_t e;
  } row_t;

  logic  clk;
  logic  rst;
  logic  req_valid;
  logic  req_ready;
  req_t  req;
  logic  rsp_valid;
  logic  rsp_ready;
  rsp_t  rsp;

  rsp_t  expected_results[$];
  int    errors;
  int    beats_in;
  int    beats_out;
  int    op_count[8];
  int    snd_idle;
  int    rcv_idle;
  int    hold_cnt;
  bit    hold_done;
  int    quiet_cyc;
  row_t  rows[$];

  complex_arithmetic_unit dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // fixed-point predictor
  // --------------------------------------------------------------------------

  // clamp to the word range, flag overflow
  function automatic logic [WORD_W-1:0] clamp_word(input wide_t v, inout bit ovf);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (WORD_W - 1)) - 1;
    lo = -(wide_t'(1) <<< (WORD_W - 1));
    if (v > hi) begin
      ovf = 1'b1;
      return hi[WORD_W-1:0];
    end
    if (v < lo) begin
      ovf = 1'b1;
      return lo[WORD_W-1:0];
    end
    return v[WORD_W-1:0];
  endfunction

  // drop fraction bits, round half away from zero
  function automatic wide_t round_frac(input wide_t v);
    logic [127:0] mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (128'(1) << (FRAC_W - 1))) >> FRAC_W;
    return (v < 0) ? -wide_t'(mag) : wide_t'(mag);
  endfunction

  function automatic void complex_mul(input logic signed [WORD_W-1:0] xr, xi, yr, yi,
                                      output logic [WORD_W-1:0] pr, pi, inout bit ovf);
    wide_t r;
    wide_t i;
    r = wide_t'(xr) * wide_t'(yr) - wide_t'(xi) * wide_t'(yi);
    i = wide_t'(xr) * wide_t'(yi) + wide_t'(xi) * wide_t'(yr);
    pr = clamp_word(round_frac(r), ovf);
    pi = clamp_word(round_frac(i), ovf);
  endfunction

  // one quotient part, rounded to nearest via one extra bit
  function automatic logic [WORD_W-1:0] quot_part(input wide_t num, input logic [127:0] den,
                                                  inout bit ovf);
    logic [127:0] mag;
    logic [127:0] q;
    mag = (num < 0) ? -num : num;
    q = ((mag << (FRAC_W + 1)) / den + 1) >> 1;
    return clamp_word((num < 0) ? -wide_t'(q) : wide_t'(q), ovf);
  endfunction

  // integer square root rounded to nearest
  function automatic logic [127:0] sqrt_round(input logic [127:0] s);
    logic [127:0] root;
    logic [127:0] cand;
    root = 0;
    for (int b = 33; b >= 0; b--) begin
      cand = root | (128'(1) << b);
      if (cand * cand <= s) root = cand;
    end
    if (s - root * root > root) root = root + 1;
    return root;
  endfunction

  function automatic rsp_t predict_alu(input req_t q);
    rsp_t o;
    bit ovf;
    wide_t ar, ai, br, bi;
    logic [127:0] den;
    logic [WORD_W-1:0] pr, pi;
    int n;
    ovf = 1'b0;
    o = '0;
    ar = wide_t'(q.a_re);
    ai = wide_t'(q.a_im);
    br = wide_t'(q.b_re);
    bi = wide_t'(q.b_im);
    n = int'(q.exponent);
    case (q.op)
      OP_ADD: begin
        o.res_re = clamp_word(ar + br, ovf);
        o.res_im = clamp_word(ai + bi, ovf);
      end
      OP_SUB: begin
        o.res_re = clamp_word(ar - br, ovf);
        o.res_im = clamp_word(ai - bi, ovf);
      end
      OP_MUL: begin
        complex_mul(q.a_re, q.a_im, q.b_re, q.b_im, pr, pi, ovf);
        o.res_re = pr;
        o.res_im = pi;
      end
      OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          o.status = ST_DIVZ;
        end else begin
          o.res_re = quot_part(ar * br + ai * bi, den, ovf);
          o.res_im = quot_part(ai * br - ar * bi, den, ovf);
        end
      end
      OP_POW: begin
        if (n == 1) begin
          o.res_re = q.a_re;
          o.res_im = q.a_im;
        end else begin
          pr = clamp_word(wide_t'(1) <<< FRAC_W, ovf);
          pi = '0;
          for (int k = 0; k < n; k++)
            complex_mul(pr, pi, q.a_re, q.a_im, pr, pi, ovf);
          o.res_re = pr;
          o.res_im = pi;
        end
      end
      OP_MAG: begin
        o.res_re = clamp_word(wide_t'(sqrt_round(ar * ar + ai * ai)), ovf);
        o.res_im = '0;
      end
      default: ;
    endcase
    if (o.status == ST_OK && ovf) o.status = ST_OVF;
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [WORD_W-1:0] pick_word(input bit near_one);
    int sel;
    sel = near_one ? 4 + $urandom_range(0, 2) : $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3: return $urandom;
      4, 5:       return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
      6:          return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      7: begin
        case ($urandom_range(0, 4))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0001_0000;
          3: return 32'hffff_0000;
          default: return '0;
        endcase
      end
      8:  return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      default: return '0;
    endcase
  endfunction

  function automatic req_t random_req();
    req_t q;
    int r;
    r = $urandom_range(0, 99);
    q.op = (r < 96) ? 3'(r % 6) : 3'($urandom_range(6, 7));
    q.a_re = pick_word(q.op == OP_POW);
    q.a_im = pick_word(q.op == OP_POW);
    q.b_re = pick_word(1'b0);
    q.b_im = pick_word(1'b0);
    // powers: mostly short, a few long
    if ($urandom_range(0, 9) == 0) q.exponent = EXP_W'($urandom);
    else q.exponent = EXP_W'($urandom_range(0, 10) - 2);
    return q;
  endfunction

  function automatic req_t mk(input logic [2:0] op, input logic [WORD_W-1:0] ar, ai, br, bi,
                              input logic [EXP_W-1:0] ex);
    req_t q;
    q.op = op;
    q.a_re = ar;
    q.a_im = ai;
    q.b_re = br;
    q.b_im = bi;
    q.exponent = ex;
    return q;
  endfunction

  function automatic row_t chk_row(input req_t q, input logic [WORD_W-1:0] er, ei,
                                   input logic [1:0] st);
    row_t w;
    w.r = q;
    w.typed = 1'b1;
    w.e.res_re = er;
    w.e.res_im = ei;
    w.e.status = st;
    return w;
  endfunction

  function automatic row_t pred_row(input req_t q);
    row_t w;
    w.r = q;
    w.typed = 1'b0;
    w.e = '0;
    return w;
  endfunction

  task automatic build_table();
    localparam logic [31:0] MX = 32'h7fff_ffff;
    localparam logic [31:0] MN = 32'h8000_0000;
    localparam logic [31:0] ONE = 32'h0001_0000;
    rows.push_back(chk_row(mk(OP_ADD, MX, MN, MX, MN, 0), MX, MN, ST_OVF));
    rows.push_back(chk_row(mk(OP_ADD, ONE, 0, ONE, 0, 0), 32'h0002_0000, 0, ST_OK));
    rows.push_back(chk_row(mk(OP_SUB, MN, MX, ONE, MN, 0), MN, MX, ST_OVF));
    rows.push_back(chk_row(mk(OP_SUB, 0, 0, 0, 0, 0), 0, 0, ST_OK));
    rows.push_back(chk_row(mk(OP_MUL, ONE, ONE, ONE, 0, 0), ONE, ONE, ST_OK));
    // real part saturates, imaginary part is MX * -1 scaled down
    rows.push_back(chk_row(mk(OP_MUL, MX, MX, MX, MN, 0), MX, 32'hffff_8000, ST_OVF));
    rows.push_back(pred_row(mk(OP_MUL, MN, MN, MN, MN, 8'h7f)));
    rows.push_back(chk_row(mk(OP_DIV, ONE, ONE, 0, 0, 0), 0, 0, ST_DIVZ));
    rows.push_back(chk_row(mk(OP_DIV, MX, MN, 0, 0, 0), 0, 0, ST_DIVZ));
    rows.push_back(chk_row(mk(OP_DIV, ONE, 0, ONE, 0, 0), ONE, 0, ST_OK));
    rows.push_back(pred_row(mk(OP_DIV, MX, MN, 32'h1, 32'h1, 0)));
    rows.push_back(pred_row(mk(OP_DIV, 32'h3, 32'hffff_fffd, MN, MX, 0)));
    rows.push_back(chk_row(mk(OP_POW, MX, MN, 0, 0, 0), ONE, 0, ST_OK));
    rows.push_back(chk_row(mk(OP_POW, 32'h1234_5678, 0, 0, 0, 8'h80), ONE, 0, ST_OK));
    rows.push_back(chk_row(mk(OP_POW, MX, MN, 0, 0, 1), MX, MN, ST_OK));
    rows.push_back(pred_row(mk(OP_POW, 32'h0000_b505, 32'h0000_b505, 0, 0, 8'd8)));
    rows.push_back(pred_row(mk(OP_POW, MX, 0, 0, 0, 8'd2)));
    rows.push_back(pred_row(mk(OP_POW, 32'h0001_0100, 32'hffff_ff00, MX, MN, 8'h7f)));
    rows.push_back(chk_row(mk(OP_MAG, MN, MN, MX, MX, 0), MX, 0, ST_OVF));
    rows.push_back(chk_row(mk(OP_MAG, 32'h0003_0000, 32'hfffc_0000, 0, 0, 0),
                           32'h0005_0000, 0, ST_OK));
    rows.push_back(chk_row(mk(OP_MAG, 0, 0, MX, MN, 8'hff), 0, 0, ST_OK));
    rows.push_back(chk_row(mk(3'd6, MX, MN, MX, MN, 8'h7f), 0, 0, ST_OK));
    rows.push_back(chk_row(mk(3'd7, MN, MX, MN, MX, 8'h80), 0, 0, ST_OK));
  endtask

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------
  task automatic send_beat(input req_t q, input rsp_t e);
    // optional gap before the beat
    if ($urandom_range(0, 99) < snd_idle) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < snd_idle);
    end
    req <= q;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    expected_results.push_back(e);
    op_count[q.op]++;
    beats_in++;
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    errors = 0;
    beats_in = 0;
    beats_out = 0;
    snd_idle = 18;
    rcv_idle = 68;
    build_table();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[k])
      send_beat(rows[k].r, rows[k].typed ? rows[k].e : predict_alu(rows[k].r));

    for (int k = 0; k < N_RANDOM; k++) begin
      req_t q;
      if (k == N_RANDOM / 3) begin
        snd_idle = 68;
        rcv_idle = 18;
      end else if (k == 2 * N_RANDOM / 3) begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      q = random_req();
      send_beat(q, predict_alu(q));
    end
    req_valid <= 1'b0;

    // drain
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    $display("checked %0d responses: add %0d sub %0d mul %0d div %0d pow %0d mag %0d other %0d",
             beats_out, op_count[0], op_count[1], op_count[2], op_count[3], op_count[4],
             op_count[5], op_count[6] + op_count[7]);
    $display("three idling patterns plus one %0d-cycle response stall, %0d errors",
             HOLD_LEN, errors);
    if (errors == 0)
      $display("complex_arithmetic_unit: match");
    else
      $display("complex_arithmetic_unit: mismatch");
    $finish;
  end

  // --------------------------------------------------------------------------
  // response side: random backpressure plus one long hold-off
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      rsp_ready <= 1'b0;
    end else if (!hold_done && beats_in >= 300) begin
      hold_done <= 1'b1;
      hold_cnt <= HOLD_LEN;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  initial rsp_ready = 1'b0;

  // compare each response beat with the oldest expected result
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && rsp_valid && rsp_ready) begin
      beats_out++;
      if (expected_results.size() == 0) begin
        $error("response beat with nothing expected: re %h im %h status %0d",
               rsp.res_re, rsp.res_im, rsp.status);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (rsp.res_re !== e.res_re) begin
          $error("res_re: expected %h, got %h", e.res_re, rsp.res_re);
          errors++;
        end
        if (rsp.res_im !== e.res_im) begin
          $error("res_im: expected %h, got %h", e.res_im, rsp.res_im);
          errors++;
        end
        if (rsp.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, rsp.status);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cyc <= 0;
    end else if (quiet_cyc >= WDOG_MAX) begin
      $display("timeout: %0d responses still expected", expected_results.size());
      $display("complex_arithmetic_unit: mismatch");
      $finish;
    end else begin
      quiet_cyc <= quiet_cyc + 1;
    end
  end

  initial quiet_cyc = 0;

endmodule

/* files.f */
rtl/cau_pkg.sv
rtl/cau_mul.sv
rtl/cau_div.sv
rtl/cau_sqrt.sv
rtl/complex_arithmetic_unit.sv
rtl/cau_checker.sv
test/tb.sv
